@@ src/sbsh_pkg.sv @@
// ============================================================================
// SHA-256 byte stream hasher package
// Round constants, initial hash values, SHA-256 logic functions and the
// control structures passed between the hasher's submodules.
// ============================================================================
package sbsh_pkg;

    // Geometry of one message block
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_BITS  = 512;
    localparam int unsigned DIGEST_WDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    // Padding constants
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [7:0] PAD_ZERO     = 8'h00;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;

    // Initial hash values
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Control to the message buffer
    typedef struct packed {
        logic       push;       // shift one byte into the block
        logic [7:0] data;       // byte to shift in
        logic       sched;      // advance the message schedule one word
    } buf_ctrl_t;

    // Control to the round core
    typedef struct packed {
        logic load;             // copy chain value into working variables
        logic round;            // run one compression round
        logic final_add;        // fold working variables into chain value
        logic init;             // restore initial hash values
    } core_ctrl_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

@@ src/sha256_byte_stream_hasher_unit.sv @@
// ============================================================================
// SHA-256 byte stream hasher
// Absorbs up to one message byte per item, compresses each full 64-byte block,
// pads on end of message and streams out the eight digest words.
// ============================================================================
// Usage:
//   Input stream s_axis: tdata = message byte, tuser = byte present,
//   tlast = end of message. Output stream m_axis: eight items per message,
//   tdata = digest word plus its index, tlast on the eighth word.
// Input: an item that neither completes a block nor ends the message is
//   taken with s_axis staying ready. The item that fills byte 64 of a block
//   starts the round core, which runs one round per cycle: 64 rounds plus
//   one chain update, and s_axis is not ready until the update is done.
// End of message: padding is pushed one byte per cycle, paused while a full
//   block compresses, through the same buffer: 0x80, zeros up to byte 56, a
//   step with no push to switch to the length, eight length bytes. One or two
//   blocks are compressed. Digest words follow, one per cycle unless stalled.
// Stall: while m_axis is stalled the word is held and no input is taken.
// Reset: chain value takes the initial hash values, fill and length clear,
//   and the block is ready for the first byte as soon as reset is released.
// ============================================================================
module sha256_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN
    } pad_phase_t;

    state_t      state_reg, state_next;
    pad_phase_t  phase_reg, phase_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic        len_done_reg, len_done_next;
    logic        pad_active_reg, pad_active_next;
    logic [2:0]  word_reg, word_next;

    buf_ctrl_t   buf_ctrl;
    core_ctrl_t  core_ctrl;
    logic [31:0] sched_word;
    logic [31:0] digest_word;
    logic [63:0] bit_len;
    logic [7:0]  len_byte;

    // Message length in bits, big-endian byte select
    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = bit_len[8 * (7 - int'(len_idx_reg)) +: 8];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {5'd0, word_reg, digest_word};
    assign m_axis_tlast  = (word_reg == WORD_LAST);

    sbsh_msg_buf u_msg_buf (
        .clk        (clk),
        .ctrl       (buf_ctrl),
        .sched_word (sched_word)
    );

    sbsh_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (core_ctrl),
        .round_k     (ROUND_K[round_reg]),
        .sched_word  (sched_word),
        .word_sel    (word_reg),
        .digest_word (digest_word)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        round_next      = round_reg;
        len_idx_next    = len_idx_reg;
        len_done_next   = len_done_reg;
        pad_active_next = pad_active_reg;
        word_next       = word_reg;
        buf_ctrl        = '0;
        core_ctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser)
                    begin
                        buf_ctrl.push = 1'b1;
                        buf_ctrl.data = s_axis_tdata;
                        count_next    = count_reg + 61'd1;
                    end
                    pad_active_next = s_axis_tlast;
                    if (s_axis_tlast)
                    begin
                        phase_next    = PH_MARK;
                        len_idx_next  = 3'd0;
                        len_done_next = 1'b0;
                        state_next    = ST_PAD;
                    end
                end
            end

            ST_ROUND:
            begin
                core_ctrl.round = 1'b1;
                buf_ctrl.sched  = 1'b1;
                round_next      = round_reg + 6'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                core_ctrl.final_add = 1'b1;
                word_next           = 3'd0;
                if (!pad_active_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end

            ST_PAD:
            begin
                case (phase_reg)
                    PH_MARK:
                    begin
                        buf_ctrl.push = 1'b1;
                        buf_ctrl.data = PAD_MARK;
                        phase_next    = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg == LEN_POS)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            buf_ctrl.push = 1'b1;
                            buf_ctrl.data = PAD_ZERO;
                        end
                    end
                    PH_LEN:
                    begin
                        buf_ctrl.push = 1'b1;
                        buf_ctrl.data = len_byte;
                        len_idx_next  = len_idx_reg + 3'd1;
                        if (len_idx_reg == WORD_LAST)
                        begin
                            len_done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_MARK;
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == WORD_LAST)
                    begin
                        core_ctrl.init  = 1'b1;
                        fill_next       = 6'd0;
                        count_next      = 61'd0;
                        pad_active_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte push; a full block starts the compression
        if (buf_ctrl.push)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg == FILL_LAST)
            begin
                core_ctrl.load = 1'b1;
                round_next     = 6'd0;
                state_next     = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_MARK;
            fill_reg       <= 6'd0;
            count_reg      <= 61'd0;
            round_reg      <= 6'd0;
            len_idx_reg    <= 3'd0;
            len_done_reg   <= 1'b0;
            pad_active_reg <= 1'b0;
            word_reg       <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            round_reg      <= round_next;
            len_idx_reg    <= len_idx_next;
            len_done_reg   <= len_done_next;
            pad_active_reg <= pad_active_next;
            word_reg       <= word_next;
        end
    end

`ifndef SYNTHESIS
    // Input and output sides never open at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest output is valid");

    // After the last digest word the block takes input again
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after last digest word");

    // Digest output starts with the most significant word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[34:32] == 3'd0))
        else $error("digest does not start at word zero");

    // Chain update only follows the last round
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |-> ($past(round_reg) == ROUND_LAST))
        else $error("chain update before all rounds ran");
`endif

endmodule

@@ src/sbsh_msg_buf.sv @@
// ============================================================================
// SHA-256 message buffer
// 512-bit window that collects block bytes and then rolls as the
// 16-word message schedule during compression.
// ============================================================================
module sbsh_msg_buf
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  buf_ctrl_t   ctrl,
    output logic [31:0] sched_word
);

    logic [BLOCK_BITS-1:0] win_reg;
    logic [BLOCK_BITS-1:0] win_next;
    logic [31:0]           w0;
    logic [31:0]           w1;
    logic [31:0]           w9;
    logic [31:0]           w14;
    logic [31:0]           w_new;

    // Schedule taps, word 0 is the oldest word in the window
    assign w0  = win_reg[511:480];
    assign w1  = win_reg[479:448];
    assign w9  = win_reg[223:192];
    assign w14 = win_reg[63:32];

    assign w_new      = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    assign sched_word = w0;

    // Byte fill or schedule roll
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.push)
        begin
            win_next = {win_reg[BLOCK_BITS-9:0], ctrl.data};
        end
        else if (ctrl.sched)
        begin
            win_next = {win_reg[BLOCK_BITS-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

@@ src/sbsh_core.sv @@
// ============================================================================
// SHA-256 round core
// Holds the chain value and the eight working variables; applies one
// compression round per cycle and the final chain update.
// ============================================================================
module sbsh_core
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctrl_t  ctrl,
    input  logic [31:0] round_k,
    input  logic [31:0] sched_word,
    input  logic [2:0]  word_sel,
    output logic [31:0] digest_word
);

    logic [31:0] chain_reg [DIGEST_WDS];
    logic [31:0] chain_next [DIGEST_WDS];
    logic [31:0] v_reg [DIGEST_WDS];
    logic [31:0] v_next [DIGEST_WDS];
    logic [31:0] t1;
    logic [31:0] t2;

    // Round arithmetic, a..h are v_reg[0..7]
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + round_k + sched_word;
    assign t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    assign digest_word = chain_reg[word_sel];

    // Working variable update
    always_comb
    begin
        v_next = v_reg;
        if (ctrl.load)
        begin
            v_next = chain_reg;
        end
        else if (ctrl.round)
        begin
            v_next[0] = t1 + t2;
            v_next[1] = v_reg[0];
            v_next[2] = v_reg[1];
            v_next[3] = v_reg[2];
            v_next[4] = v_reg[3] + t1;
            v_next[5] = v_reg[4];
            v_next[6] = v_reg[5];
            v_next[7] = v_reg[6];
        end
    end

    // Chain value update
    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.init)
        begin
            chain_next = INIT_HASH;
        end
        else if (ctrl.final_add)
        begin
            for (int i = 0; i < DIGEST_WDS; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_HASH;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

endmodule
